// ===== hw/rtl/dns_name_text_to_wire_defines.svh =====
// Assertion macros for the DNS name text-to-wire converter.
// Used by the port checker; needs clk and rst_n in the calling scope.
`ifndef DNS_NAME_TEXT_TO_WIRE_DEFINES_SVH
`define DNS_NAME_TEXT_TO_WIRE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define DNSW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define DNSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, active through reset.
`define DNSW_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dnsw_pkg.sv =====
// Shared types and constants of the DNS name text-to-wire converter.
// No dependencies.
`default_nettype none

package dnsw_pkg;

    localparam int unsigned MAX_LABEL_DEF = 63;
    localparam int unsigned MAX_NAME_DEF  = 255;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;

    localparam logic [BYTE_W-1:0] NUL_CHAR = 8'd0;
    localparam logic [BYTE_W-1:0] DOT_CHAR = 8'd46;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_LABEL_LONG  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY_LABEL = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NAME_LONG   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ABS     = 3'd4;

    typedef enum logic [1:0] {
        PH_START,
        PH_LEAD_DOT,
        PH_IN_NAME,
        PH_DISCARD
    } phase_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_EMIT
    } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dnsw_char_if.sv =====
// Character channel: valid/ready handshake carrying one text character.
// Depends on dnsw_pkg.
`default_nettype none

interface dnsw_char_if;
    import dnsw_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dnsw_wire_if.sv =====
// Wire-format channel: valid/ready handshake carrying one output octet.
// Depends on dnsw_pkg.
`default_nettype none

interface dnsw_wire_if;
    import dnsw_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   wire_byte;
    logic                end_of_name;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output wire_byte, output end_of_name, output status,
                    input ready);
    modport sink   (input valid, input wire_byte, input end_of_name, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dns_name_text_to_wire.sv =====
// DNS name text-to-wire converter, top level.
// Depends on dnsw_pkg, dnsw_char_if, dnsw_wire_if and dnsw_ram.
//
// Usage:
//   text   : sink channel, one name character per item; a zero byte ends
//            the name, '.' separates labels.
//   octets : source channel, one wire-format octet per item with its
//            end_of_name flag and status code.
//   Label characters go into a label RAM, one write per character. A dot
//   emits the length octet the cycle after it is taken, then streams the
//   label out of the RAM one octet per cycle unless octets stalls; text is
//   not taken during the stream. A character is thus written once and read
//   once through the single RAM read port, and a label blocks the input
//   while it streams after its dot.
//   The first result of an item shows on octets the cycle after it is taken.
//   An error gives one result with end_of_name set; unless it came on a zero
//   byte, characters are then dropped through the next terminator.
//   Reset clears the name state and empties the output register; the RAM
//   needs no clearing. When octets stalls, the output register holds and
//   text stops being taken.
`default_nettype none

module dns_name_text_to_wire #(
    parameter int unsigned MAX_LABEL = dnsw_pkg::MAX_LABEL_DEF,
    parameter int unsigned MAX_NAME  = dnsw_pkg::MAX_NAME_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dnsw_char_if.sink   text,
    dnsw_wire_if.source octets
);
    import dnsw_pkg::*;

    localparam int unsigned AW  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int unsigned LCW = $clog2(MAX_LABEL + 1);
    localparam int unsigned WCW = $clog2(MAX_NAME + 1);
    localparam int unsigned SW  = ((WCW > LCW) ? WCW : LCW) + 1;

    ctl_t                ctl_reg, ctl_next;
    phase_t              phase_reg, phase_next;
    logic [LCW-1:0]      label_count_reg, label_count_next;
    logic [WCW-1:0]      wire_count_reg, wire_count_next;
    logic [LCW-1:0]      idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_eon_reg, out_eon_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic              out_free;
    logic              in_ready;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    dnsw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LABEL),
        .ADDR_W(AW)
    ) u_label_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(text.char_in),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !out_valid_reg || octets.ready;

    always_comb
    begin
        logic [BYTE_W-1:0]   c;
        logic                err;
        logic [STATUS_W-1:0] err_status;
        logic                load;
        logic [SW-1:0]       name_sum;
        logic [LCW:0]        idx_inc;

        c          = text.char_in;
        err        = 1'b0;
        err_status = STATUS_OK;
        load       = 1'b0;
        name_sum   = SW'(wire_count_reg) + SW'(label_count_reg) + SW'(1);
        idx_inc    = (LCW + 1)'(idx_reg) + (LCW + 1)'(1);

        ctl_next         = ctl_reg;
        phase_next       = phase_reg;
        label_count_next = label_count_reg;
        wire_count_next  = wire_count_reg;
        idx_next         = idx_reg;
        out_byte_next    = out_byte_reg;
        out_eon_next     = out_eon_reg;
        out_status_next  = out_status_reg;
        in_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = label_count_reg[AW-1:0];
        ram_re           = 1'b0;
        ram_raddr        = idx_reg[AW-1:0];

        case (ctl_reg)
            CTL_IDLE:
            begin
                in_ready = out_free;
                if (text.valid && out_free)
                begin
                    case (phase_reg)
                        PH_START:
                        begin
                            if (c == NUL_CHAR)
                            begin
                                err        = 1'b1;
                                err_status = STATUS_NOT_ABS;
                            end
                            else if (c == DOT_CHAR)
                            begin
                                phase_next = PH_LEAD_DOT;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                ram_waddr        = '0;
                                label_count_next = LCW'(1);
                                wire_count_next  = '0;
                                phase_next       = PH_IN_NAME;
                            end
                        end
                        PH_LEAD_DOT:
                        begin
                            if (c == NUL_CHAR)
                            begin
                                load             = 1'b1;
                                out_byte_next    = '0;
                                out_eon_next     = 1'b1;
                                out_status_next  = STATUS_OK;
                                label_count_next = '0;
                                wire_count_next  = '0;
                                phase_next       = PH_START;
                            end
                            else
                            begin
                                err        = 1'b1;
                                err_status = STATUS_EMPTY_LABEL;
                            end
                        end
                        PH_IN_NAME:
                        begin
                            if (name_sum >= SW'(MAX_NAME))
                            begin
                                err        = 1'b1;
                                err_status = STATUS_NAME_LONG;
                            end
                            else if (c == DOT_CHAR)
                            begin
                                if (label_count_reg == '0)
                                begin
                                    err        = 1'b1;
                                    err_status = STATUS_EMPTY_LABEL;
                                end
                                else
                                begin
                                    load            = 1'b1;
                                    out_byte_next   = BYTE_W'(label_count_reg);
                                    out_eon_next    = 1'b0;
                                    out_status_next = STATUS_OK;
                                    wire_count_next = WCW'(name_sum);
                                    idx_next        = '0;
                                    ram_re          = 1'b1;
                                    ram_raddr       = '0;
                                    ctl_next        = CTL_EMIT;
                                end
                            end
                            else if (c == NUL_CHAR)
                            begin
                                if (label_count_reg != '0)
                                begin
                                    err        = 1'b1;
                                    err_status = STATUS_NOT_ABS;
                                end
                                else
                                begin
                                    load             = 1'b1;
                                    out_byte_next    = '0;
                                    out_eon_next     = 1'b1;
                                    out_status_next  = STATUS_OK;
                                    label_count_next = '0;
                                    wire_count_next  = '0;
                                    phase_next       = PH_START;
                                end
                            end
                            else if (label_count_reg >= LCW'(MAX_LABEL))
                            begin
                                err        = 1'b1;
                                err_status = STATUS_LABEL_LONG;
                            end
                            else
                            begin
                                ram_we           = 1'b1;
                                label_count_next = label_count_reg + LCW'(1);
                            end
                        end
                        PH_DISCARD:
                        begin
                            if (c == NUL_CHAR)
                            begin
                                label_count_next = '0;
                                wire_count_next  = '0;
                                phase_next       = PH_START;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_START;
                        end
                    endcase

                    if (err)
                    begin
                        load             = 1'b1;
                        out_byte_next    = '0;
                        out_eon_next     = 1'b1;
                        out_status_next  = err_status;
                        label_count_next = '0;
                        wire_count_next  = '0;
                        phase_next       = (c == NUL_CHAR) ? PH_START : PH_DISCARD;
                    end
                end
            end
            CTL_EMIT:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    out_byte_next   = ram_rdata;
                    out_eon_next    = 1'b0;
                    out_status_next = STATUS_OK;
                    idx_next        = LCW'(idx_inc);
                    if (idx_inc == (LCW + 1)'(label_count_reg))
                    begin
                        label_count_next = '0;
                        ctl_next         = CTL_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[AW-1:0];
                    end
                end
            end
            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (octets.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg         <= CTL_IDLE;
            phase_reg       <= PH_START;
            label_count_reg <= '0;
            wire_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ctl_reg         <= ctl_next;
            phase_reg       <= phase_next;
            label_count_reg <= label_count_next;
            wire_count_reg  <= wire_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        out_byte_reg   <= out_byte_next;
        out_eon_reg    <= out_eon_next;
        out_status_reg <= out_status_next;
    end

    assign text.ready         = in_ready;
    assign octets.valid       = out_valid_reg;
    assign octets.wire_byte   = out_byte_reg;
    assign octets.end_of_name = out_eon_reg;
    assign octets.status      = out_status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dnsw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module dnsw_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 63,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dnsw_checker.sv =====
// Port-level checks for the DNS name text-to-wire converter, with bind.
// Depends on dnsw_pkg and dns_name_text_to_wire_defines.svh.
`default_nettype none

`include "dns_name_text_to_wire_defines.svh"

module dnsw_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [dnsw_pkg::BYTE_W-1:0]   wire_byte,
    input wire logic                          end_of_name,
    input wire logic [dnsw_pkg::STATUS_W-1:0] status
);
    import dnsw_pkg::*;

    logic                     stalled;
    logic                     is_error;
    logic                     error_shape_ok;
    logic [BYTE_W+STATUS_W:0] out_item;

    assign stalled        = out_valid && !out_ready;
    assign is_error       = out_valid && (status != STATUS_OK);
    assign error_shape_ok = end_of_name && (wire_byte == '0);
    assign out_item       = {wire_byte, end_of_name, status};

    `DNSW_ASSERT_ALWAYS(a_empty_after_reset, $rose(rst_n), !out_valid, "item after reset")
    `DNSW_ASSERT_SAME(a_stall_blocks_input, stalled, !in_ready, "input taken while stalled")
    `DNSW_ASSERT_SAME(a_error_shape, is_error, error_shape_ok, "error item not final or nonzero")
    `DNSW_ASSERT_NEXT(a_stall_holds, stalled, out_valid && $stable(out_item), "stalled item changed")

endmodule

bind dns_name_text_to_wire dnsw_checker u_dnsw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (text.ready),
    .out_valid  (octets.valid),
    .out_ready  (octets.ready),
    .wire_byte  (octets.wire_byte),
    .end_of_name(octets.end_of_name),
    .status     (octets.status)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for dns_name_text_to_wire: directed names, then random names with input idles
// and output stalls. Output octets are checked against an internal name-state predictor,
// or a directed row's octet; needs dnsw_pkg and the dnsw_char_if / dnsw_wire_if interfaces.

module tb_top;
    import dnsw_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]   wire_byte;
        logic                end_of_name;
        logic [STATUS_W-1:0] status;
    } octet_t;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        bit                typed;
        octet_t            want;
    } text_row_t;

    typedef enum {NM_WELL, NM_BROKEN, NM_NOISE, NM_LABEL_MAX, NM_LABEL_OVER, NM_NAME_OVER}
        name_kind_t;
    typedef enum {BR_NO_TRAIL, BR_DOUBLE_DOT, BR_LEAD_DOT, BR_EMPTY} broken_t;

    localparam int NUM_ROWS      = 18;
    localparam int PHASE_ITEMS   = 24;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;

    dnsw_char_if text_ch ();
    dnsw_wire_if octet_ch ();

    dns_name_text_to_wire u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .octets (octet_ch)
    );

    phase_t            name_phase;
    logic [BYTE_W-1:0] label_buf [MAX_LABEL_DEF];
    int                label_len;
    int                octets_out;

    octet_t     expected_octets[$];
    int         fail_count;
    int         sent_items;
    int         send_idle;
    int         stall_pct;
    bit         row_typed;
    octet_t     row_want;
    text_row_t  directed_rows [NUM_ROWS];

    function automatic octet_t make_octet(input logic [BYTE_W-1:0] b, input logic eon,
                                          input logic [STATUS_W-1:0] st);
        octet_t o;
        o.wire_byte   = b;
        o.end_of_name = eon;
        o.status      = st;
        return o;
    endfunction

    function automatic void clear_name_state();
        label_len  = 0;
        octets_out = 0;
        name_phase = PH_START;
    endfunction

    function automatic void flag_name_error(input logic [STATUS_W-1:0] st,
                                            input logic [BYTE_W-1:0] c, ref octet_t res[$]);
        res.push_back(make_octet(NUL_CHAR, 1'b1, st));
        label_len  = 0;
        octets_out = 0;
        name_phase = (c == NUL_CHAR) ? PH_START : PH_DISCARD;
    endfunction

    function automatic void advance_name(input logic [BYTE_W-1:0] c, ref octet_t res[$]);
        res.delete();
        case (name_phase)
            PH_START:
            begin
                if (c == NUL_CHAR)
                    flag_name_error(STATUS_NOT_ABS, c, res);
                else if (c == DOT_CHAR)
                    name_phase = PH_LEAD_DOT;
                else
                begin
                    label_buf[0] = c;
                    label_len    = 1;
                    octets_out   = 0;
                    name_phase   = PH_IN_NAME;
                end
            end
            PH_LEAD_DOT:
            begin
                if (c == NUL_CHAR)
                begin
                    res.push_back(make_octet(NUL_CHAR, 1'b1, STATUS_OK));
                    clear_name_state();
                end
                else
                    flag_name_error(STATUS_EMPTY_LABEL, c, res);
            end
            PH_IN_NAME:
            begin
                if (octets_out + 1 + label_len >= MAX_NAME_DEF)
                    flag_name_error(STATUS_NAME_LONG, c, res);
                else if (c == DOT_CHAR)
                begin
                    if (label_len == 0)
                        flag_name_error(STATUS_EMPTY_LABEL, c, res);
                    else
                    begin
                        res.push_back(make_octet(BYTE_W'(label_len), 1'b0, STATUS_OK));
                        for (int i = 0; i < label_len; i++)
                            res.push_back(make_octet(label_buf[i], 1'b0, STATUS_OK));
                        octets_out = (octets_out + label_len + 1) & 8'hFF;
                        label_len  = 0;
                    end
                end
                else if (c == NUL_CHAR)
                begin
                    if (label_len != 0)
                        flag_name_error(STATUS_NOT_ABS, c, res);
                    else
                    begin
                        res.push_back(make_octet(NUL_CHAR, 1'b1, STATUS_OK));
                        clear_name_state();
                    end
                end
                else if (label_len >= MAX_LABEL_DEF)
                    flag_name_error(STATUS_LABEL_LONG, c, res);
                else
                begin
                    label_buf[label_len] = c;
                    label_len++;
                end
            end
            default:
            begin
                if (c == NUL_CHAR)
                    clear_name_state();
            end
        endcase
    endfunction

    function automatic int pick_label_len();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    endfunction

    function automatic void add_label(ref logic [BYTE_W-1:0] chars[$], input int n);
        logic [BYTE_W-1:0] c;
        repeat (n)
        begin
            do
                c = BYTE_W'($urandom_range(1, 255));
            while (c == DOT_CHAR);
            chars.push_back(c);
        end
    endfunction

    function automatic void build_name(input name_kind_t kind, ref logic [BYTE_W-1:0] chars[$]);
        int      r;
        broken_t fault;
        chars.delete();
        case (kind)
            NM_WELL:
            begin
                if ($urandom_range(0, 14) == 0)
                    chars.push_back(DOT_CHAR);
                else
                    repeat ($urandom_range(1, 4))
                    begin
                        add_label(chars, pick_label_len());
                        chars.push_back(DOT_CHAR);
                    end
            end
            NM_BROKEN:
            begin
                fault = broken_t'($urandom_range(0, 3));
                case (fault)
                    BR_NO_TRAIL:
                    begin
                        add_label(chars, pick_label_len());
                        chars.push_back(DOT_CHAR);
                        add_label(chars, pick_label_len());
                    end
                    BR_DOUBLE_DOT:
                    begin
                        add_label(chars, pick_label_len());
                        chars.push_back(DOT_CHAR);
                        chars.push_back(DOT_CHAR);
                        add_label(chars, pick_label_len());
                        chars.push_back(DOT_CHAR);
                    end
                    BR_LEAD_DOT:
                    begin
                        chars.push_back(DOT_CHAR);
                        add_label(chars, pick_label_len());
                        chars.push_back(DOT_CHAR);
                    end
                    default: ;
                endcase
            end
            NM_NOISE:
            begin
                repeat ($urandom_range(1, 12))
                begin
                    r = $urandom_range(0, 3);
                    if (r == 0)
                        chars.push_back(DOT_CHAR);
                    else if (r == 1)
                        chars.push_back(NUL_CHAR);
                    else
                        chars.push_back(BYTE_W'($urandom_range(0, 255)));
                end
            end
            NM_LABEL_MAX:
            begin
                add_label(chars, MAX_LABEL_DEF);
                chars.push_back(DOT_CHAR);
                add_label(chars, 2);
                chars.push_back(DOT_CHAR);
            end
            NM_LABEL_OVER:
            begin
                add_label(chars, MAX_LABEL_DEF + 1);
                add_label(chars, 3);
                chars.push_back(DOT_CHAR);
            end
            default:
            begin
                repeat (4)
                begin
                    add_label(chars, MAX_LABEL_DEF);
                    chars.push_back(DOT_CHAR);
                end
            end
        endcase
        if (kind != NM_NOISE)
            chars.push_back(NUL_CHAR);
    endfunction

    task automatic send_char(input logic [BYTE_W-1:0] c, input bit typed, input octet_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.char_in <= c;
        row_typed       <= typed;
        row_want        <= want;
        do
            @(posedge clk);
        while (!text_ch.ready);
        sent_items++;
    endtask

    task automatic drain_octets();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (expected_octets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge clk)
        octet_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        octet_t got;
        octet_t want;
        octet_t res[$];
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            advance_name(text_ch.char_in, res);
            if (row_typed)
                expected_octets.push_back(row_want);
            else
                foreach (res[i])
                    expected_octets.push_back(res[i]);
        end
        if (rst_n && octet_ch.valid && octet_ch.ready)
        begin
            got = make_octet(octet_ch.wire_byte, octet_ch.end_of_name, octet_ch.status);
            if (expected_octets.size() == 0)
            begin
                $error("unexpected octet: wire_byte %0d end_of_name %0d status %0d",
                       got.wire_byte, got.end_of_name, got.status);
                fail_count++;
            end
            else
            begin
                want = expected_octets.pop_front();
                if (got.wire_byte !== want.wire_byte)
                begin
                    $error("wire_byte: expected %0d, got %0d", want.wire_byte, got.wire_byte);
                    fail_count++;
                end
                if (got.end_of_name !== want.end_of_name)
                begin
                    $error("end_of_name: expected %0d, got %0d",
                           want.end_of_name, got.end_of_name);
                    fail_count++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] name_chars[$];
        int                idle_sets  [4];
        int                stall_sets [4];
        name_kind_t        special    [4];
        int                r;

        idle_sets  = '{0, 70, 0, 35};
        stall_sets = '{0, 0, 70, 35};
        special    = '{NM_WELL, NM_LABEL_OVER, NM_WELL, NM_NAME_OVER};

        rst_n           = 1'b0;
        text_ch.valid   = 1'b0;
        text_ch.char_in = NUL_CHAR;
        octet_ch.ready  = 1'b0;
        row_typed       = 1'b0;
        row_want        = '0;
        fail_count      = 0;
        sent_items      = 0;
        send_idle       = 0;
        stall_pct       = 0;
        clear_name_state();

        directed_rows = '{
            '{NUL_CHAR, 1'b1, make_octet(NUL_CHAR, 1'b1, STATUS_NOT_ABS)},
            '{DOT_CHAR, 1'b0, '0},
            '{NUL_CHAR, 1'b1, make_octet(NUL_CHAR, 1'b1, STATUS_OK)},
            '{DOT_CHAR, 1'b0, '0},
            '{8'h61,    1'b1, make_octet(NUL_CHAR, 1'b1, STATUS_EMPTY_LABEL)},
            '{8'h62,    1'b0, '0},
            '{NUL_CHAR, 1'b0, '0},
            '{8'h61,    1'b0, '0},
            '{DOT_CHAR, 1'b0, '0},
            '{NUL_CHAR, 1'b1, make_octet(NUL_CHAR, 1'b1, STATUS_OK)},
            '{8'hFF,    1'b0, '0},
            '{8'h01,    1'b0, '0},
            '{DOT_CHAR, 1'b0, '0},
            '{DOT_CHAR, 1'b1, make_octet(NUL_CHAR, 1'b1, STATUS_EMPTY_LABEL)},
            '{8'h7F,    1'b0, '0},
            '{NUL_CHAR, 1'b0, '0},
            '{8'h80,    1'b0, '0},
            '{NUL_CHAR, 1'b1, make_octet(NUL_CHAR, 1'b1, STATUS_NOT_ABS)}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
        drain_octets();

        for (int p = 0; p < 4; p++)
        begin
            send_idle  = idle_sets[p];
            stall_pct  = stall_sets[p];
            sent_items = 0;
            if (name_phase != PH_START)
                send_char(NUL_CHAR, 1'b0, '0);
            build_name(special[p], name_chars);
            foreach (name_chars[i])
                send_char(name_chars[i], 1'b0, '0);
            while (sent_items < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 9);
                build_name((r < 7) ? NM_WELL : (r < 8) ? NM_BROKEN : NM_NOISE, name_chars);
                foreach (name_chars[i])
                    send_char(name_chars[i], 1'b0, '0);
            end
            drain_octets();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dnsw_pkg.sv
hw/rtl/dnsw_char_if.sv
hw/rtl/dnsw_wire_if.sv
hw/rtl/dnsw_ram.sv
hw/rtl/dns_name_text_to_wire.sv
hw/rtl/dnsw_checker.sv
tb/sv/tb_top.sv
